>>> rtl/sfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfu_pkg: shared types and constants
// Result word layout and message and kind codes of the upload engine.
// ----------------------------------------------------------------------------
package sfu_pkg;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_DONE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_REQ  = 2'd3;

	localparam logic [2:0] KIND_MSG   = 3'd0;
	localparam logic [2:0] KIND_STOP  = 3'd1;
	localparam logic [2:0] KIND_ERASE = 3'd2;
	localparam logic [2:0] KIND_PROG  = 3'd3;
	localparam logic [2:0] KIND_DATA  = 3'd4;

	localparam logic [2:0] MSG_READY = 3'd0;
	localparam logic [2:0] MSG_HDR   = 3'd1;
	localparam logic [2:0] MSG_ERS   = 3'd2;
	localparam logic [2:0] MSG_ACK   = 3'd3;
	localparam logic [2:0] MSG_DONE  = 3'd4;
	localparam logic [2:0] MSG_FAIL  = 3'd5;

	localparam logic [0:0] REG_TIMEOUT = 1'd0;
	localparam logic [0:0] REG_MAXUP   = 1'd1;

	localparam logic [15:0] TIMEOUT_RST = 16'd10000;
	localparam logic [24:0] MAXUP_RST   = 25'd15728640;
	localparam logic [24:0] UPLOAD_CAP  = 25'd16777216;
	localparam logic [24:0] SAT25       = 25'h1FFFFFF;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  message;
		logic [31:0] flash_addr;
		logic [24:0] length;
		logic [7:0]  data_byte;
		logic        last;
	} res_t;

	// Up to two results per word; data byte is filled in by the back end.
	typedef struct packed {
		logic       two;
		res_t       r0;
		res_t       r1;
		logic       rd;
	} job_t;

	function automatic res_t mk(input logic [2:0] k, input logic [2:0] m,
		input logic [31:0] a, input logic [24:0] l);
		res_t r;
		r.kind = k;
		r.message = m;
		r.flash_addr = a;
		r.length = l;
		r.data_byte = 8'd0;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] trig(input logic [3:0] i);
		case (i)
			4'd0: return 8'h50;
			4'd1: return 8'h43;
			4'd2: return 8'h4D;
			4'd3: return 8'h55;
			4'd4: return 8'h50;
			4'd5: return 8'h4C;
			4'd6: return 8'h4F;
			4'd7: return 8'h41;
			4'd8: return 8'h44;
			4'd9: return 8'h0A;
			default: return 8'h00;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/serial_flash_upload_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_flash_upload_engine: serial upload to flash
// Trigger match, header and chunk protocol, paged programming feed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) carries op, rx_byte, flash_ok; one word per
//   cycle is accepted while the job queue has room.
//   Output channel (valid/ready) carries kind, message, flash_addr, length,
//   data_byte and last; an input word yields zero, one or two results.
//   The first result follows acceptance through the state update and buffer
//   read, then the queue write. Throughput: one input word per cycle; a
//   word with two results holds the output for both results, which the job
//   queue (up to three jobs held) absorbs.
//   When the output is stalled the queue fills and in_ready drops.
//   Reset clears all control state and the config registers to defaults;
//   the chunk buffer holds stale data, read only where freshly written.
//   cfg_we/cfg_idx/cfg_data write the receive timeout (0) or max_upload_bytes
//   (1); the user must write only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module serial_flash_upload_engine #(
	parameter int CHUNK_BYTES = 2048,
	parameter int PAGE_BYTES = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_idx,
	input  wire  [24:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  op,
	input  wire  [7:0]  rx_byte,
	input  wire         flash_ok,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  kind,
	output logic [2:0]  message,
	output logic [31:0] flash_addr,
	output logic [24:0] length,
	output logic [7:0]  data_byte,
	output logic        last
);
	localparam int AW = $clog2(CHUNK_BYTES);

	logic wr_en, job_vld, space;
	logic [AW-1:0] wr_addr, rd_addr;
	sfu_pkg::job_t job;
	sfu_pkg::res_t res;

	assign in_ready = space;

	sfu_front #(.CHUNK_BYTES(CHUNK_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .fire(in_valid && in_ready), .op(op),
		.rx_byte(rx_byte), .flash_ok(flash_ok), .wr_en(wr_en), .wr_addr(wr_addr),
		.rd_addr(rd_addr), .job_vld(job_vld), .job(job)
	);

	sfu_back #(.CHUNK_BYTES(CHUNK_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data(rx_byte), .rd_addr(rd_addr), .job_vld(job_vld), .job(job),
		.space(space), .out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign kind = res.kind;
	assign message = res.message;
	assign flash_addr = res.flash_addr;
	assign length = res.length;
	assign data_byte = res.data_byte;
	assign last = res.last;

`ifndef ASSERT_OFF
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("result pair split");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != sfu_pkg::KIND_MSG) |-> (message == sfu_pkg::MSG_READY))
		else $error("message on non-message kind");
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != sfu_pkg::KIND_DATA) |-> (data_byte == 8'd0))
		else $error("data on non-data kind");
`endif
endmodule
`default_nettype wire

>>> rtl/sfu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfu_front: protocol engine
// Classifies each word, updates the upload state, writes the chunk buffer
// and issues jobs of one or two results toward the back end.
// ----------------------------------------------------------------------------
module sfu_front #(
	parameter int CHUNK_BYTES = 2048,
	parameter int PAGE_BYTES = 256
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire  [0:0]              cfg_idx,
	input  wire  [24:0]             cfg_data,
	input  wire                     fire,
	input  wire  [1:0]              op,
	input  wire  [7:0]              rx_byte,
	input  wire                     flash_ok,
	output logic                    wr_en,
	output logic [$clog2(CHUNK_BYTES)-1:0] wr_addr,
	output logic [$clog2(CHUNK_BYTES)-1:0] rd_addr,
	output logic                    job_vld,
	output sfu_pkg::job_t           job
);
	localparam int AW = $clog2(CHUNK_BYTES);
	localparam int CW = $clog2(CHUNK_BYTES + 1);
	localparam int PW = $clog2(PAGE_BYTES);
	localparam int SW = $clog2(PAGE_BYTES + 1);

	localparam logic [2:0] PH_MATCH = 3'd0;
	localparam logic [2:0] PH_HDR   = 3'd1;
	localparam logic [2:0] PH_ERASE = 3'd2;
	localparam logic [2:0] PH_LEN   = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_FEED  = 3'd5;
	localparam logic [2:0] PH_PWAIT = 3'd6;

	logic [15:0] tmo_q;
	logic [24:0] maxup_q;
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  midx_q, midx_d;
	logic [2:0]  fbc_q, fbc_d;
	logic [31:0] base_q, base_d;
	logic [24:0] total_q, total_d;
	logic [24:0] bw_q, bw_d;
	logic [CW-1:0] clen_q, clen_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] poff_q, poff_d;
	logic [SW-1:0] segl_q, segl_d;
	logic [15:0] wt_q, wt_d;
	sfu_pkg::job_t jd;
	logic        jv;

	logic [31:0] cur;
	logic [SW-1:0] room;
	logic [CW-1:0] segc;
	logic [SW-1:0] seg;
	logic [24:0] lim;
	logic [24:0] remain;
	logic [15:0] raw;
	logic [15:0] wtn;

	always_comb begin
		cur = base_q + {7'd0, bw_q};
		room = SW'(PAGE_BYTES) - {1'b0, cur[PW-1:0]};
		segc = clen_q - poff_q;
		seg = ({{(32-CW){1'b0}}, segc} > 32'(room)) ? room : SW'(segc);
		lim = (maxup_q > sfu_pkg::UPLOAD_CAP) ? sfu_pkg::UPLOAD_CAP : maxup_q;
		remain = total_q - bw_q;
		raw = {rx_byte, clen_q[7:0]};
		wtn = (wt_q != 16'hFFFF) ? wt_q + 16'd1 : wt_q;
	end

	always_comb begin
		phase_d = phase_q; midx_d = midx_q; fbc_d = fbc_q; base_d = base_q;
		total_d = total_q; bw_d = bw_q; clen_d = clen_q; fill_d = fill_q;
		poff_d = poff_q; segl_d = segl_q; wt_d = wt_q;
		jv = 1'b0; jd = '0;
		wr_en = 1'b0; wr_addr = fill_q[AW-1:0]; rd_addr = poff_q[AW-1:0];
		if (fire) begin
			case (op)
				sfu_pkg::OP_BYTE: begin
					case (phase_q)
						PH_MATCH: begin
							if (midx_q < 4'd10 && rx_byte == sfu_pkg::trig(midx_q)) begin
								midx_d = midx_q + 4'd1;
								if (midx_q == 4'd9) begin
									midx_d = 4'd0;
									jv = 1'b1; jd.two = 1'b1;
									jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_STOP, 3'd0, 32'd0, 25'd0);
									jd.r1 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_READY,
										32'd0, 25'd0);
									phase_d = PH_HDR; fbc_d = 3'd0; base_d = 32'd0;
									total_d = 25'd0; wt_d = 16'd0;
								end
							end else begin
								midx_d = 4'd0;
							end
						end
						PH_HDR: begin
							case (fbc_q)
								3'd0: base_d[7:0] = rx_byte;
								3'd1: base_d[15:8] = rx_byte;
								3'd2: base_d[23:16] = rx_byte;
								3'd3: base_d[31:24] = rx_byte;
								3'd4: total_d[7:0] = rx_byte;
								3'd5: total_d[15:8] = rx_byte;
								3'd6: total_d[23:16] = rx_byte;
								default: if (rx_byte != 8'd0) total_d = sfu_pkg::SAT25;
							endcase
							fbc_d = fbc_q + 3'd1;
							if (fbc_q == 3'd7) begin
								jv = 1'b1;
								if (total_d == 25'd0 || total_d > lim) begin
									jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_FAIL,
										32'd0, 25'd0);
									phase_d = PH_MATCH; midx_d = 4'd0;
								end else begin
									jd.two = 1'b1;
									jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_HDR,
										32'd0, 25'd0);
									jd.r1 = sfu_pkg::mk(sfu_pkg::KIND_ERASE, 3'd0, base_q,
										total_d);
									bw_d = 25'd0; phase_d = PH_ERASE;
								end
							end
						end
						PH_LEN: begin
							if (fbc_q == 3'd0) begin
								clen_d = CW'(rx_byte); fbc_d = 3'd1;
							end else if (raw == 16'd0 || 32'(raw) > CHUNK_BYTES) begin
								jv = 1'b1;
								jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_FAIL,
									32'd0, 25'd0);
								phase_d = PH_MATCH; midx_d = 4'd0;
							end else begin
								clen_d = ({9'd0, raw} > remain) ? CW'(remain) : CW'(raw);
								fill_d = '0; wt_d = 16'd0; phase_d = PH_DATA;
							end
						end
						PH_DATA: begin
							wr_en = 1'b1;
							fill_d = fill_q + CW'(1);
							if (fill_d >= clen_q) begin
								poff_d = '0;
								// first segment: program offset is zero here
								segl_d = ({{(32-CW){1'b0}}, clen_q} > 32'(room)) ? room
									: SW'(clen_q);
								phase_d = PH_FEED; jv = 1'b1;
								jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_PROG, 3'd0, cur,
									25'(segl_d));
							end
						end
						default: ;
					endcase
				end
				sfu_pkg::OP_DONE: begin
					if (phase_q == PH_ERASE || phase_q == PH_PWAIT) begin
						jv = 1'b1;
						if (!flash_ok) begin
							jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_FAIL,
								32'd0, 25'd0);
							phase_d = PH_MATCH; midx_d = 4'd0;
						end else if (phase_q == PH_ERASE) begin
							jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_ERS,
								32'd0, 25'd0);
							phase_d = PH_LEN; fbc_d = 3'd0; clen_d = '0; wt_d = 16'd0;
						end else if (poff_q < clen_q) begin
							segl_d = seg; phase_d = PH_FEED;
							jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_PROG, 3'd0, cur, 25'(seg));
						end else begin
							jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_ACK,
								32'd0, 25'd0);
							if (bw_q >= total_q) begin
								jd.two = 1'b1;
								jd.r1 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_DONE,
									32'd0, 25'd0);
								phase_d = PH_MATCH; midx_d = 4'd0;
							end else begin
								phase_d = PH_LEN; fbc_d = 3'd0; clen_d = '0; wt_d = 16'd0;
							end
						end
					end
				end
				sfu_pkg::OP_TICK: begin
					if (phase_q == PH_HDR || phase_q == PH_LEN || phase_q == PH_DATA) begin
						wt_d = wtn;
						if (wtn >= tmo_q) begin
							jv = 1'b1;
							jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_MSG, sfu_pkg::MSG_FAIL,
								32'd0, 25'd0);
							phase_d = PH_MATCH; midx_d = 4'd0;
						end
					end
				end
				default: begin
					if (phase_q == PH_FEED && segl_q != '0) begin
						jv = 1'b1; jd.rd = 1'b1;
						jd.r0 = sfu_pkg::mk(sfu_pkg::KIND_DATA, 3'd0, 32'd0, 25'd0);
						poff_d = poff_q + CW'(1);
						bw_d = bw_q + 25'd1;
						segl_d = segl_q - SW'(1);
						if (segl_q == SW'(1)) phase_d = PH_PWAIT;
					end
				end
			endcase
		end
		if (jd.two) jd.r1.last = 1'b1;
		else jd.r0.last = 1'b1;
	end

	assign job_vld = jv;
	assign job = jd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q <= sfu_pkg::TIMEOUT_RST; maxup_q <= sfu_pkg::MAXUP_RST;
			phase_q <= PH_MATCH; midx_q <= '0; fbc_q <= '0; base_q <= '0;
			total_q <= '0; bw_q <= '0; clen_q <= '0; fill_q <= '0; poff_q <= '0;
			segl_q <= '0; wt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == sfu_pkg::REG_TIMEOUT) tmo_q <= cfg_data[15:0];
				else maxup_q <= cfg_data;
			end
			phase_q <= phase_d; midx_q <= midx_d; fbc_q <= fbc_d; base_q <= base_d;
			total_q <= total_d; bw_q <= bw_d; clen_q <= clen_d; fill_q <= fill_d;
			poff_q <= poff_d; segl_q <= segl_d; wt_q <= wt_d;
		end
	end

`ifndef ASSERT_OFF
	a_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FEED) |-> (segl_q <= SW'(PAGE_BYTES)))
		else $error("segment exceeds page");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (fill_q < clen_q))
		else $error("chunk overfill");
	a_clen: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FEED || phase_q == PH_PWAIT) |-> (poff_q <= clen_q))
		else $error("program offset past chunk");
`endif
endmodule
`default_nettype wire

>>> rtl/sfu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfu_back: chunk buffer, job queue and result output
// Holds buffered bytes, queues jobs, and streams results one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sfu_back #(
	parameter int CHUNK_BYTES = 2048
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     wr_en,
	input  wire  [$clog2(CHUNK_BYTES)-1:0] wr_addr,
	input  wire  [7:0]              wr_data,
	input  wire  [$clog2(CHUNK_BYTES)-1:0] rd_addr,
	input  wire                     job_vld,
	input  sfu_pkg::job_t           job,
	output logic                    space,
	output logic                    out_valid,
	input  wire                     out_ready,
	output sfu_pkg::res_t           res
);
	localparam int AW = $clog2(CHUNK_BYTES);

	logic [7:0] mem [CHUNK_BYTES];
	logic [7:0] rd_s1;
	logic       jv_s1;
	sfu_pkg::job_t job_s1;

	// queue of four jobs
	sfu_pkg::job_t q_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       half_q;
	sfu_pkg::job_t qj;
	logic pop, push;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1 <= mem[rd_addr];
	end

	always_comb begin
		qj = job_s1;
		if (job_s1.rd) qj.r0.data_byte = rd_s1;
	end

	assign push = jv_s1;
	assign out_valid = cnt_q != 3'd0;
	assign res = half_q ? q_q[rp_q].r1 : q_q[rp_q].r0;
	assign pop = out_valid && out_ready && (half_q || !q_q[rp_q].two);
	// room for the in-flight job plus one
	assign space = cnt_q + {2'd0, jv_s1} < 3'd3;

	always_ff @(posedge clk) begin
		job_s1 <= job;
		if (push) q_q[wp_q] <= qj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_s1 <= 1'b0; wp_q <= '0; rp_q <= '0; cnt_q <= '0; half_q <= 1'b0;
		end else begin
			jv_s1 <= job_vld;
			if (push) wp_q <= wp_q + 2'd1;
			if (out_valid && out_ready) half_q <= !pop;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("job queue overflow");
	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (out_valid && q_q[rp_q].two)) else $error("bad half select");
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr < AW'(CHUNK_BYTES - 1) || wr_addr == AW'(CHUNK_BYTES - 1)))
		else $error("buffer address");
`endif
endmodule
`default_nettype wire
